// File: rtl/wvca_pkg.sv
package wvca_pkg;

  localparam int NUM_IN_PORTS     = 5;
  localparam int NUM_VCS          = 4;
  localparam int QUEUE_DEPTH      = 4;
  localparam int MAX_PACKET_FLITS = 16;
  localparam int CREDIT_MAX       = 255;

  localparam int NUM_QUEUES  = NUM_IN_PORTS * NUM_VCS;
  localparam int NUM_ENTRIES = NUM_QUEUES * QUEUE_DEPTH;

  localparam int Q_W  = $clog2(NUM_QUEUES);
  localparam int E_W  = $clog2(NUM_ENTRIES);
  localparam int H_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int C_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CR_W = $clog2(CREDIT_MAX + 1);
  localparam int I_W  = $clog2(NUM_VCS + 2);
  localparam int J_W  = $clog2(NUM_IN_PORTS + 1);
  localparam int SUM_W = ((CR_W > 8) ? CR_W : 8) + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WTA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC = 2'd2;

  typedef enum logic [2:0] {
    FN_REQ    = 3'd0,
    FN_FLIT   = 3'd1,
    FN_ACK    = 3'd2,
    FN_TICK   = 3'd3,
    FN_CREDIT = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    OC_GRANT    = 3'd0,
    OC_NOTHING  = 3'd1,
    OC_BLOCKED  = 3'd2,
    OC_AWAIT    = 3'd3,
    OC_MISMATCH = 3'd4,
    OC_NOT_TICK = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DISC      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_EOP_ERR   = 3'd4,
    ST_NAK_EMPTY = 3'd5,
    ST_CREDIT    = 3'd6,
    ST_BAD_FUNC  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KD_MID   = 2'd0,
    KD_START = 2'd1,
    KD_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] in_port;
    logic [1:0] out_vc;
    logic [1:0] in_vc;
    logic [4:0] num_flits;
    logic       end_of_packet;
    logic       ack_ok;
    logic [7:0] credit_count;
  } req_t;

  typedef struct packed {
    logic       grant_valid;
    logic [2:0] grant_in_port;
    logic [1:0] grant_out_vc;
    logic [1:0] grant_in_vc;
    logic [1:0] grant_kind;
    logic [2:0] arb_outcome;
    logic       flit_forwarded;
    logic [2:0] status;
    logic [6:0] pending_requests;
  } res_t;

  typedef struct packed {
    logic [1:0] in_vc;
    logic [4:0] length;
    logic [4:0] granted;
    logic [4:0] acked;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [Q_W-1:0] qnum(logic [2:0] port, logic [1:0] vc);
    return Q_W'(Q_W'(port) * Q_W'(NUM_VCS) + Q_W'(vc));
  endfunction

  function automatic logic [H_W-1:0] slot_add(logic [H_W-1:0] h, logic [C_W-1:0] off);
    logic [C_W:0] s;
    s = (C_W+1)'(h) + (C_W+1)'(off);
    if (s >= (C_W+1)'(QUEUE_DEPTH)) begin
      s = s - (C_W+1)'(QUEUE_DEPTH);
    end
    return H_W'(s);
  endfunction

  function automatic logic [E_W-1:0] eaddr(logic [Q_W-1:0] q, logic [H_W-1:0] slot);
    return E_W'(E_W'(q) * E_W'(QUEUE_DEPTH) + E_W'(slot));
  endfunction

endpackage

// File: rtl/wvca_if.sv
interface wvca_req_if;
  logic          valid;
  logic          ready;
  wvca_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wvca_res_if;
  logic          valid;
  logic          ready;
  wvca_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/wvca_ram.sv
module wvca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wormhole_output_vc_arbiter_top.sv
// Channel   Dir  Payload  Handshake
// in_req    in   req_t    valid/ready, taken when both are high
// out_res   out  res_t    valid/ready, taken when both are high
// cfg_*     in   idx,bit  write when cfg_we is high, no wait
// A request, credit, bad event, ack, or flit or nak on an empty queue goes from decode
// straight to the result; a flit or nak on a non-empty queue passes an execute state first.
// A tick's result waits for the scan that visits one queue per cycle
// through the queue state mux and the single read port of the request store. Reset is
// synchronous and clears all queue, credit and scan state; the request store needs no
// clearing. The input is not ready from acceptance until the result has been taken.
module wormhole_output_vc_arbiter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  wvca_req_if.sink                           in_req,
  wvca_res_if.source                         out_res,
  input  logic                               cfg_we,
  input  logic [wvca_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic                               cfg_wdata
);
  import wvca_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_EXEC, S_VC, S_CUR, S_PORT, S_SEL, S_HEAD, S_NEXT, S_OUT
  } state_t;

  state_t state_r;
  req_t   req_r;
  res_t   res_r;

  logic wta_r, spec_r, disc_r;

  logic [H_W-1:0]  q_head_r [NUM_QUEUES];
  logic [C_W-1:0]  q_cnt_r  [NUM_QUEUES];
  logic [CR_W-1:0] credits_r  [NUM_VCS];
  logic [2:0]      cur_port_r [NUM_VCS];
  logic            cur_valid_r [NUM_VCS];
  logic [H_W-1:0]  cur_slot_r [NUM_VCS];
  logic [1:0]      scan_vc_r;
  logic [6:0]      total_r;

  logic [I_W-1:0]  i_r;
  logic [J_W-1:0]  j_r;
  logic [1:0]      vc_r;
  logic [2:0]      ip_r;
  logic [2:0]      sp_r;
  logic [E_W-1:0]  ea_r;
  logic [1:0]      ivc_hold_r;

  logic [Q_W-1:0]  q_in, qa;
  logic [H_W-1:0]  qh;
  logic [C_W-1:0]  qc;
  logic [1:0]      vc_cur;
  logic [2:0]      ip_cur, p_cur;
  logic            port_bad;
  logic [4:0]      nfl_c;

  logic            ram_we;
  logic [E_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t          rd, wr;

  logic [SUM_W-1:0] cadd_n, csum;
  logic             c_ovf;
  logic [CR_W-1:0]  c_new;
  logic             rd_full;
  logic [4:0]       gr_inc;
  logic [1:0]       kind_c;
  logic             eop_bad;

  wvca_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd      = entry_t'(ram_rdata);
  assign rd_full = (rd.granted == rd.length);
  assign gr_inc  = rd.granted + 5'd1;
  assign kind_c  = (rd.granted == 5'd0) ? KD_START : (gr_inc == rd.length) ? KD_END : KD_MID;
  assign eop_bad = !rd_full || ((6'(rd.acked) + 6'd1) != 6'(rd.length));
  assign q_in    = qnum(req_r.in_port, req_r.out_vc);
  assign port_bad = (int'(req_r.in_port) >= NUM_IN_PORTS) || (int'(req_r.out_vc) >= NUM_VCS);

  always_comb begin
    logic [I_W:0] vs;
    logic [J_W+2:0] ps;
    vs = (I_W+1)'(scan_vc_r) + (I_W+1)'(i_r);
    if (vs >= (I_W+1)'(NUM_VCS)) begin
      vs = vs - (I_W+1)'(NUM_VCS);
    end
    if (vs >= (I_W+1)'(NUM_VCS)) begin
      vs = vs - (I_W+1)'(NUM_VCS);
    end
    vc_cur = 2'(vs);
    ip_cur = cur_port_r[vc_cur];
    ps = (J_W+3)'(ip_r) + (J_W+3)'(j_r);
    if (ps >= (J_W+3)'(NUM_IN_PORTS)) begin
      ps = ps - (J_W+3)'(NUM_IN_PORTS);
    end
    p_cur = 3'(ps);
  end

  always_comb begin
    case (state_r)
      S_VC:                   qa = qnum(ip_cur, vc_cur);
      S_PORT:                 qa = qnum(p_cur, vc_r);
      S_SEL, S_HEAD, S_NEXT:  qa = qnum(sp_r, vc_r);
      default:                qa = q_in;
    endcase
    qh = q_head_r[qa];
    qc = q_cnt_r[qa];
  end

  always_comb begin
    nfl_c = req_r.num_flits;
    if (nfl_c == 5'd0) begin
      nfl_c = 5'd1;
    end
    if (int'(nfl_c) > MAX_PACKET_FLITS) begin
      nfl_c = 5'(MAX_PACKET_FLITS);
    end
  end

  always_comb begin
    cadd_n = (state_r == S_EXEC) ? SUM_W'(1) : SUM_W'(req_r.credit_count);
    csum   = SUM_W'(credits_r[req_r.out_vc]) + cadd_n;
    c_ovf  = (csum > SUM_W'(CREDIT_MAX));
    c_new  = c_ovf ? CR_W'(CREDIT_MAX) : CR_W'(csum);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ea_r;
    ram_raddr = ea_r;
    wr        = rd;
    case (state_r)
      S_DEC: begin
        ram_raddr = eaddr(q_in, qh);
        if (req_r.func == FN_REQ && !port_bad && !disc_r &&
            int'(qc) < QUEUE_DEPTH) begin
          ram_we    = 1'b1;
          ram_waddr = eaddr(q_in, slot_add(qh, qc));
          wr        = '{in_vc: req_r.in_vc, length: nfl_c, granted: 5'd0, acked: 5'd0};
        end
      end
      S_EXEC: begin
        if (req_r.func == FN_FLIT && !req_r.end_of_packet) begin
          ram_we   = 1'b1;
          wr.acked = (rd.acked == '1) ? rd.acked : rd.acked + 5'd1;
        end else if (req_r.func == FN_ACK && rd.granted != 5'd0) begin
          ram_we     = 1'b1;
          wr.granted = rd.granted - 5'd1;
        end
      end
      S_VC: ram_raddr = eaddr(qa, qh);
      S_SEL: ram_raddr = eaddr(qa, qh);
      S_HEAD: begin
        ram_raddr = eaddr(qa, slot_add(qh, C_W'(1)));
        if (!rd_full) begin
          ram_we     = 1'b1;
          wr.granted = gr_inc;
        end
      end
      S_NEXT: begin
        if (rd.in_vc == ivc_hold_r) begin
          ram_we     = 1'b1;
          wr.granted = gr_inc;
        end
      end
      default: ;
    endcase
    ram_wdata = ENTRY_W'(wr);
  end

  assign in_req.ready = (state_r == S_IDLE);
  assign out_res.valid = (state_r == S_OUT);

  always_comb begin
    out_res.data = res_r;
    out_res.data.pending_requests = total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wta_r     <= 1'b0;
      spec_r    <= 1'b0;
      disc_r    <= 1'b0;
      scan_vc_r <= 2'(NUM_VCS - 1);
      total_r   <= '0;
      for (int k = 0; k < NUM_QUEUES; k++) begin
        q_head_r[k] <= '0;
        q_cnt_r[k]  <= '0;
      end
      for (int k = 0; k < NUM_VCS; k++) begin
        credits_r[k]   <= '0;
        cur_port_r[k]  <= '0;
        cur_valid_r[k] <= 1'b0;
        cur_slot_r[k]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WTA:  wta_r  <= cfg_wdata;
          CFG_SPEC: spec_r <= cfg_wdata;
          CFG_DISC: disc_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            req_r   <= in_req.data;
            res_r   <= '{arb_outcome: OC_NOT_TICK, status: ST_OK, default: '0};
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          ea_r <= eaddr(q_in, qh);
          if (req_r.func > FN_CREDIT || (req_r.func != FN_TICK &&
              req_r.func != FN_CREDIT && port_bad)) begin
            res_r.status <= ST_BAD_FUNC;
            state_r      <= S_OUT;
          end else begin
            case (func_t'(req_r.func))
              FN_REQ: begin
                state_r <= S_OUT;
                if (disc_r) begin
                  res_r.status <= ST_DISC;
                end else if (int'(qc) >= QUEUE_DEPTH) begin
                  res_r.status <= ST_FULL;
                end else begin
                  q_cnt_r[q_in] <= qc + C_W'(1);
                  total_r       <= total_r + 7'd1;
                end
              end
              FN_FLIT: begin
                if (qc == '0) begin
                  res_r.status <= ST_EMPTY;
                  state_r      <= S_OUT;
                end else begin
                  state_r <= S_EXEC;
                end
              end
              FN_ACK: begin
                if (!req_r.ack_ok) begin
                  if (qc == '0) begin
                    res_r.status <= ST_NAK_EMPTY;
                    state_r      <= S_OUT;
                  end else begin
                    state_r <= S_EXEC;
                  end
                end else begin
                  state_r <= S_OUT;
                end
              end
              FN_TICK: begin
                if (total_r == '0) begin
                  res_r.arb_outcome <= OC_NOTHING;
                  state_r           <= S_OUT;
                end else begin
                  i_r     <= wta_r ? I_W'(0) : I_W'(1);
                  state_r <= S_VC;
                end
              end
              FN_CREDIT: begin
                state_r                 <= S_OUT;
                credits_r[req_r.out_vc] <= c_new;
                if (c_ovf) begin
                  res_r.status <= ST_CREDIT;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_EXEC: begin
          state_r <= S_OUT;
          if (req_r.func == FN_FLIT) begin
            res_r <= '{flit_forwarded: 1'b1, arb_outcome: OC_NOT_TICK,
                       status: (req_r.end_of_packet && eop_bad) ? ST_EOP_ERR : ST_OK,
                       default: '0};
            if (req_r.end_of_packet) begin
              if (cur_valid_r[req_r.out_vc] && cur_port_r[req_r.out_vc] == req_r.in_port &&
                  cur_slot_r[req_r.out_vc] == qh) begin
                cur_valid_r[req_r.out_vc] <= 1'b0;
              end
              q_head_r[q_in] <= slot_add(qh, C_W'(1));
              q_cnt_r[q_in]  <= qc - C_W'(1);
              total_r        <= total_r - 7'd1;
            end
          end else begin
            if (rd.granted == 5'd0) begin
              res_r.status <= ST_NAK_EMPTY;
            end else begin
              credits_r[req_r.out_vc] <= c_new;
              if (c_ovf) begin
                res_r.status <= ST_CREDIT;
              end
            end
          end
        end
        S_VC: begin
          if (int'(i_r) > NUM_VCS) begin
            res_r.arb_outcome <= OC_NOTHING;
            state_r           <= S_OUT;
          end else if (credits_r[vc_cur] == '0) begin
            i_r <= i_r + I_W'(1);
          end else begin
            vc_r <= vc_cur;
            ip_r <= ip_cur;
            j_r  <= J_W'(1);
            if (cur_valid_r[vc_cur] && qc != '0 && qh == cur_slot_r[vc_cur]) begin
              state_r <= S_CUR;
            end else begin
              state_r <= S_PORT;
            end
          end
        end
        S_CUR: begin
          if (!rd_full) begin
            sp_r    <= ip_r;
            state_r <= S_SEL;
          end else begin
            state_r <= S_PORT;
          end
        end
        S_PORT: begin
          if (qc != '0) begin
            sp_r    <= p_cur;
            state_r <= S_SEL;
          end else if (int'(j_r) == NUM_IN_PORTS) begin
            i_r     <= i_r + I_W'(1);
            state_r <= S_VC;
          end else begin
            j_r <= j_r + J_W'(1);
          end
        end
        S_SEL: begin
          if (cur_valid_r[vc_r] && !(cur_port_r[vc_r] == sp_r && cur_slot_r[vc_r] == qh)) begin
            res_r.arb_outcome <= OC_BLOCKED;
            state_r           <= S_OUT;
          end else begin
            scan_vc_r        <= vc_r;
            cur_port_r[vc_r] <= sp_r;
            ea_r             <= eaddr(qa, qh);
            state_r          <= S_HEAD;
          end
        end
        S_HEAD, S_NEXT: begin
          if (state_r == S_HEAD && rd_full) begin
            if (!spec_r) begin
              res_r.arb_outcome <= OC_AWAIT;
              state_r           <= S_OUT;
            end else if (qc < C_W'(2)) begin
              res_r.arb_outcome <= OC_MISMATCH;
              state_r           <= S_OUT;
            end else begin
              ivc_hold_r <= rd.in_vc;
              ea_r       <= eaddr(qa, slot_add(qh, C_W'(1)));
              state_r    <= S_NEXT;
            end
          end else if (state_r == S_NEXT && rd.in_vc != ivc_hold_r) begin
            res_r.arb_outcome <= OC_MISMATCH;
            state_r           <= S_OUT;
          end else begin
            state_r           <= S_OUT;
            cur_valid_r[vc_r] <= 1'b1;
            cur_slot_r[vc_r]  <= (state_r == S_NEXT) ? slot_add(qh, C_W'(1)) : qh;
            credits_r[vc_r]   <= credits_r[vc_r] - CR_W'(1);
            res_r <= '{grant_valid: 1'b1, grant_in_port: sp_r, grant_out_vc: vc_r,
                       grant_in_vc: rd.in_vc, grant_kind: kind_c, arb_outcome: OC_GRANT,
                       default: '0};
            if (wta_r && gr_inc == rd.length) begin
              scan_vc_r <= (int'(vc_r) == NUM_VCS - 1) ? 2'd0 : vc_r + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (out_res.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wvca_pkg::*;

  class grant_scoreboard;
    bit          wta, spec, disc;
    int unsigned ent_ivc[NUM_ENTRIES], ent_len[NUM_ENTRIES];
    int unsigned ent_gnt[NUM_ENTRIES], ent_ack[NUM_ENTRIES];
    int unsigned q_head[NUM_QUEUES], q_cnt[NUM_QUEUES];
    int unsigned vc_cred[NUM_VCS], vc_port[NUM_VCS], vc_busy[NUM_VCS], vc_slot[NUM_VCS];
    int unsigned scan_pos, total;
    res_t        expected_results[$];
    int          errors;

    function new();
      foreach (q_head[k]) begin
        q_head[k] = 0;
        q_cnt[k] = 0;
      end
      foreach (vc_cred[k]) begin
        vc_cred[k] = 0;
        vc_port[k] = 0;
        vc_busy[k] = 0;
        vc_slot[k] = 0;
      end
      scan_pos = NUM_VCS - 1;
      total = 0;
      errors = 0;
      wta = 0;
      spec = 0;
      disc = 0;
    endfunction

    function int unsigned slot_of(int unsigned q, int unsigned off);
      return q * QUEUE_DEPTH + (q_head[q] + off) % QUEUE_DEPTH;
    endfunction

    function void add_credit(int unsigned vc, int unsigned n, ref status_t st);
      int unsigned sum;
      sum = vc_cred[vc] + n;
      if (sum > CREDIT_MAX) begin
        sum = CREDIT_MAX;
        st = ST_CREDIT;
      end
      vc_cred[vc] = sum;
    endfunction

    function outcome_t arbitrate_tick(ref res_t r);
      int unsigned sv, sp, q, e, e2, pos, prev, vc, ip, cq;
      bit found;
      found = 0;
      sv = 0;
      sp = 0;
      if (total == 0) return OC_NOTHING;
      for (int i = wta ? 0 : 1; !found && i <= NUM_VCS; i++) begin
        vc = (scan_pos + i) % NUM_VCS;
        ip = vc_port[vc];
        cq = ip * NUM_VCS + vc;
        if (vc_cred[vc] == 0) continue;
        if (vc_busy[vc] && q_cnt[cq] != 0 && q_head[cq] == vc_slot[vc]) begin
          e = slot_of(cq, 0);
          if (ent_gnt[e] != ent_len[e]) begin
            sv = vc;
            sp = ip;
            found = 1;
            break;
          end
        end
        for (int j = 1; !found && j <= NUM_IN_PORTS; j++) begin
          if (q_cnt[((ip + j) % NUM_IN_PORTS) * NUM_VCS + vc] != 0) begin
            sv = vc;
            sp = (ip + j) % NUM_IN_PORTS;
            found = 1;
          end
        end
      end
      if (!found) return OC_NOTHING;
      q = sp * NUM_VCS + sv;
      pos = q_head[q];
      if (vc_busy[sv] && !(vc_port[sv] == sp && vc_slot[sv] == pos)) return OC_BLOCKED;
      scan_pos = sv;
      vc_port[sv] = sp;
      e = slot_of(q, 0);
      if (ent_gnt[e] == ent_len[e]) begin
        if (!spec) return OC_AWAIT;
        if (q_cnt[q] < 2) return OC_MISMATCH;
        e2 = slot_of(q, 1);
        if (ent_ivc[e2] != ent_ivc[e]) return OC_MISMATCH;
        e = e2;
        pos = (pos + 1) % QUEUE_DEPTH;
      end
      vc_busy[sv] = 1;
      vc_slot[sv] = pos;
      prev = ent_gnt[e];
      ent_gnt[e] = prev + 1;
      vc_cred[sv] -= 1;
      r.grant_valid = 1;
      r.grant_in_port = sp;
      r.grant_out_vc = sv;
      r.grant_in_vc = ent_ivc[e];
      if (prev == 0) r.grant_kind = KD_START;
      else if (ent_gnt[e] == ent_len[e]) r.grant_kind = KD_END;
      else r.grant_kind = KD_MID;
      if (wta && ent_gnt[e] == ent_len[e]) scan_pos = (sv + 1) % NUM_VCS;
      return OC_GRANT;
    endfunction

    function void note_request(req_t rq);
      res_t        r;
      status_t     st;
      outcome_t    oc;
      int unsigned fn, port, vc, q, e, nfl;
      bit          port_bad;
      r = '0;
      st = ST_OK;
      oc = OC_NOT_TICK;
      fn = rq.func;
      port = rq.in_port;
      vc = rq.out_vc;
      port_bad = port >= NUM_IN_PORTS || vc >= NUM_VCS;
      q = port_bad ? 0 : port * NUM_VCS + vc;
      if (fn > 4 || (fn <= 2 && port_bad) || (fn == 4 && vc >= NUM_VCS)) begin
        st = ST_BAD_FUNC;
      end else if (fn == FN_REQ) begin
        if (disc) st = ST_DISC;
        else if (q_cnt[q] >= QUEUE_DEPTH) st = ST_FULL;
        else begin
          nfl = rq.num_flits;
          if (nfl == 0) nfl = 1;
          if (nfl > MAX_PACKET_FLITS) nfl = MAX_PACKET_FLITS;
          e = slot_of(q, q_cnt[q]);
          ent_ivc[e] = rq.in_vc;
          ent_len[e] = nfl;
          ent_gnt[e] = 0;
          ent_ack[e] = 0;
          q_cnt[q]++;
          total++;
        end
      end else if (fn == FN_FLIT) begin
        if (q_cnt[q] == 0) st = ST_EMPTY;
        else begin
          e = slot_of(q, 0);
          r.flit_forwarded = 1;
          if (rq.end_of_packet) begin
            if (ent_gnt[e] != ent_len[e] || ent_ack[e] + 1 != ent_len[e]) st = ST_EOP_ERR;
            if (vc_busy[vc] && vc_port[vc] == port && vc_slot[vc] == q_head[q])
              vc_busy[vc] = 0;
            q_head[q] = (q_head[q] + 1) % QUEUE_DEPTH;
            q_cnt[q]--;
            total--;
          end else if (ent_ack[e] < 255) begin
            ent_ack[e]++;
          end
        end
      end else if (fn == FN_ACK) begin
        if (!rq.ack_ok) begin
          if (q_cnt[q] == 0 || ent_gnt[slot_of(q, 0)] == 0) st = ST_NAK_EMPTY;
          else begin
            ent_gnt[slot_of(q, 0)]--;
            add_credit(vc, 1, st);
          end
        end
      end else if (fn == FN_TICK) begin
        oc = arbitrate_tick(r);
      end else begin
        add_credit(vc, rq.credit_count, st);
      end
      r.arb_outcome = oc;
      r.status = st;
      r.pending_requests = total;
      expected_results = {expected_results, r};
    endfunction

    function void compare_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
        return;
      end
      e = expected_results[0];
      expected_results.delete(0);
      compare_field("grant_valid", e.grant_valid, a.grant_valid);
      compare_field("grant_in_port", e.grant_in_port, a.grant_in_port);
      compare_field("grant_out_vc", e.grant_out_vc, a.grant_out_vc);
      compare_field("grant_in_vc", e.grant_in_vc, a.grant_in_vc);
      compare_field("grant_kind", e.grant_kind, a.grant_kind);
      compare_field("arb_outcome", e.arb_outcome, a.arb_outcome);
      compare_field("flit_forwarded", e.flit_forwarded, a.flit_forwarded);
      compare_field("status", e.status, a.status);
      compare_field("pending_requests", e.pending_requests, a.pending_requests);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic cfg_wdata;
  int src_idle, snk_idle;
  bit hold_req;
  grant_scoreboard sb;

  wvca_req_if rq();
  wvca_res_if rs();

  wormhole_output_vc_arbiter_top dut (
    .clk(clk), .rst_n(rst_n), .in_req(rq), .out_res(rs),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rs.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rs.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 0;
      end
      rs.ready = ($urandom_range(99) >= snk_idle);
      @(posedge clk);
      if (rs.valid && rs.ready) sb.check_result(rs.data);
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < src_idle) begin
      rq.valid = 1'b0;
      @(negedge clk);
    end
    rq.valid = 1'b1;
    rq.data = r;
    do @(posedge clk); while (!rq.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, bit v);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    rq.valid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_mode(bit w, bit s, bit d);
    write_cfg(CFG_WTA, w);
    write_cfg(CFG_SPEC, s);
    write_cfg(CFG_DISC, d);
    sb.wta = w;
    sb.spec = s;
    sb.disc = d;
  endtask

  function automatic req_t make_event(func_t f, int p, int v);
    req_t r;
    r = $urandom;
    r.func = f;
    r.in_port = p;
    r.out_vc = v;
    return r;
  endfunction

  function automatic req_t random_event();
    req_t r;
    int unsigned pick, q, e;
    r = $urandom;
    pick = $urandom_range(99);
    if (pick >= 95) return r;
    r.in_port = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(NUM_IN_PORTS - 1);
    if (pick < 22) begin
      r.func = FN_REQ;
      if ($urandom_range(7) != 0) r.num_flits = $urandom_range(4, 1);
      if ($urandom_range(2) != 0) r.in_vc = r.out_vc;
    end else if (pick < 55) begin
      r.func = FN_TICK;
    end else if (pick < 77) begin
      r.func = FN_FLIT;
      for (int k = 0; k < 8; k++) begin
        q = r.in_port * NUM_VCS + r.out_vc;
        if (r.in_port < NUM_IN_PORTS && sb.q_cnt[q] != 0) break;
        r.in_port = $urandom_range(NUM_IN_PORTS - 1);
        r.out_vc = $urandom;
      end
      if (r.in_port < NUM_IN_PORTS && sb.q_cnt[q] != 0) begin
        e = sb.slot_of(q, 0);
        r.end_of_packet = (sb.ent_gnt[e] == sb.ent_len[e] && sb.ent_ack[e] + 1 >= sb.ent_len[e]);
        if ($urandom_range(9) == 0) r.end_of_packet = ~r.end_of_packet;
      end
    end else if (pick < 87) begin
      r.func = FN_ACK;
    end else begin
      r.func = FN_CREDIT;
      if ($urandom_range(9) != 0) r.credit_count = $urandom_range(8);
    end
    return r;
  endfunction

  initial begin
    req_t r;
    int n;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = 1'b0;
    rq.valid = 1'b0;
    rq.data = '0;
    hold_req = 0;
    src_idle = 0;
    snk_idle = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_mode(0, 0, 0);
    send_request(make_event(FN_TICK, 0, 0));
    send_request(make_event(FN_FLIT, 1, 1));
    r = make_event(FN_ACK, 2, 2);
    r.ack_ok = 0;
    send_request(r);
    r = make_event(FN_CREDIT, 0, 0);
    r.credit_count = 8'd255;
    send_request(r);
    send_request(r);
    r.out_vc = 3;
    r.credit_count = 8'd0;
    send_request(r);
    for (int k = 5; k < 8; k++) send_request(make_event(func_t'(k), 0, 0));
    send_request(make_event(FN_REQ, 7, 3));
    for (int k = 0; k < 5; k++) begin
      r = make_event(FN_REQ, 4, 0);
      r.num_flits = (k == 0) ? 5'd0 : (k == 1) ? 5'd31 : 5'd2;
      r.in_vc = (k == 3) ? 2'd1 : 2'd3;
      send_request(r);
    end
    send_request(make_event(FN_TICK, 0, 0));
    send_request(make_event(FN_TICK, 0, 0));
    r = make_event(FN_FLIT, 4, 0);
    r.end_of_packet = 1;
    send_request(r);
    send_request(make_event(FN_TICK, 0, 0));
    r = make_event(FN_ACK, 4, 0);
    r.ack_ok = 0;
    send_request(r);
    r.ack_ok = 1;
    send_request(r);
    r = make_event(FN_FLIT, 4, 0);
    r.end_of_packet = 0;
    send_request(r);
    send_request(make_event(FN_TICK, 0, 0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_mode(0, 0, 0);
        1: set_mode(1, 0, 0);
        2: set_mode(0, 1, 0);
        3: set_mode(1, 1, 0);
        4: set_mode(1, 1, 1);
        5: set_mode(0, 1, 0);
        default: set_mode(1, 0, 0);
      endcase
      src_idle = (ph < 2) ? 22 : (ph < 4) ? 53 : 0;
      snk_idle = (ph < 2) ? 53 : (ph < 4) ? 22 : 0;
      if (ph == 2) hold_req = 1;
      n = (ph == 4) ? 60 : 230;
      for (int k = 0; k < n; k++) send_request(random_event());
      drain();
    end

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/wvca_pkg.sv
rtl/wvca_if.sv
rtl/wvca_ram.sv
rtl/wormhole_output_vc_arbiter_top.sv
verif/tb_top.sv
